>>> rtl/smsm_pkg.sv
package smsm_pkg;

   // Field widths of the transactions.
   localparam int unsigned ADDR_W      = 5;
   localparam int unsigned CMD_W       = 8;
   localparam int unsigned STATE_W     = 3;
   localparam int unsigned MODE_W      = 2;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 5;
   localparam int unsigned REQ_DATA_W  = 16;
   localparam int unsigned RSP_DATA_W  = 16;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_RUN_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SS_ADDR   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROG_ADDR = 2'd2;

   // Run modes.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOTE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [MODE_W-1:0] RESET_RUN_MODE  = MODE_REMOTE;
   localparam logic [ADDR_W-1:0] RESET_SS_ADDR   = 5'd7;
   localparam logic [ADDR_W-1:0] RESET_PROG_ADDR = 5'd11;

   // A programmed command pair always has an even stop command.
   localparam logic [CMD_W-1:0] CMD_PAIR_MASK = 8'hFE;

   // Request payload, last field in the lowest bits.
   typedef struct packed {
      logic [1:0]        pad;
      logic              button_pressed;
      logic [CMD_W-1:0]  msg_command;
      logic [ADDR_W-1:0] msg_address;
   } req_data_type;

   // Response payload, last field in the lowest bits.
   typedef struct packed {
      logic               pad;
      logic [STATE_W-1:0] persist_state;
      logic [CMD_W-1:0]   stop_code;
      logic               started_now;
      logic [STATE_W-1:0] run_state;
   } rsp_data_type;

endpackage

>>> rtl/start_module_state_machine_unit.sv
// Channel   Direction  Handshake             Payload
// req_      in         req_tvalid/tready     tuser: msg_valid; tdata: address, command, button
// rsp_      out        rsp_tvalid/tready     tdata: run_state, started_now, stop_code, persist_state
// csr_      in         csr_valid/csr_ready   csr_index selects the register, csr_data the value
//
// Every poll tick passes through the input register and then the state
// update, which writes the response register. A new tick is accepted
// in every cycle as long as the response register drains.
// Reset is synchronous and active high; it restores the power-on state,
// the default command pair and the default configuration.
// A stalled response holds the input register, which then stalls requests.
module start_module_state_machine_unit (
   input  logic                                clock,
   input  logic                                reset,
   // Request transaction: tuser = msg_valid.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_tuser,
   // tdata from bit 0: msg_address[4:0], msg_command[12:5], button_pressed[13], zeros.
   input  logic [smsm_pkg::REQ_DATA_W-1:0]     req_tdata,
   // Response transaction.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata from bit 0: run_state[2:0], started_now[3], stop_code[11:4],
   // persist_state[14:12], zero.
   output logic [smsm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Configuration write transaction.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [smsm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [smsm_pkg::CSR_DATA_W-1:0]     csr_data
);

   import smsm_pkg::*;

   // Run state encoding, also used for the persisted state.
   typedef enum logic [STATE_W-1:0] {
      ST_PROG        = 3'd0,
      ST_POWER_ON    = 3'd1,
      ST_STARTED     = 3'd2,
      ST_STOPPED_SAFE = 3'd3,
      ST_STOPPED     = 3'd4
   } state_type;

   // Configuration registers.
   logic [MODE_W-1:0] run_mode_ff;
   logic [ADDR_W-1:0] ss_addr_ff;
   logic [ADDR_W-1:0] prog_addr_ff;

   // Controller state.
   state_type         state_ff;
   state_type         state_in;
   logic [CMD_W-1:0]  stop_cmd_ff;
   logic [CMD_W-1:0]  stop_cmd_in;
   logic              prog_pending_ff;
   logic              prog_pending_in;
   logic              button_latched_ff;
   logic              button_latched_in;

   // Input register.
   logic              in_valid_ff;
   logic              in_msg_valid_ff;
   req_data_type      in_data_ff;

   // Response register.
   logic              rsp_valid_ff;
   rsp_data_type      rsp_data_ff;
   rsp_data_type      rsp_data_in;

   logic              req_accept;
   logic              advance;
   logic              csr_write;
   logic [CMD_W-1:0]  start_cmd;
   logic              on_ss;
   logic              on_prog;
   logic              is_start;
   logic              is_stop;
   state_type         msg_state;
   state_type         saved;

   // The tick in the input register moves on when the response register
   // is empty or is being emptied in this cycle.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The start command always follows the stop command.
   assign start_cmd = stop_cmd_ff + 8'd1;
   assign on_ss     = in_data_ff.msg_address == ss_addr_ff;
   assign on_prog   = in_data_ff.msg_address == prog_addr_ff;
   assign is_start  = on_ss && (in_data_ff.msg_command == start_cmd);
   assign is_stop   = on_ss && (in_data_ff.msg_command == stop_cmd_ff);

   always_comb begin
      state_in          = state_ff;
      stop_cmd_in       = stop_cmd_ff;
      prog_pending_in   = prog_pending_ff;
      button_latched_in = button_latched_ff;
      msg_state         = state_ff;

      case (run_mode_ff)
         MODE_REMOTE: begin
            // Message handling; a programming message wins over start/stop.
            if (in_msg_valid_ff) begin
               if (state_ff == ST_POWER_ON) begin
                  if (is_start) begin
                     msg_state = ST_STARTED;
                  end
                  if (is_stop) begin
                     msg_state = ST_STOPPED_SAFE;
                  end
               end else if (state_ff == ST_STARTED) begin
                  if (is_stop) begin
                     msg_state = ST_STOPPED_SAFE;
                  end
               end
               if ((state_ff == ST_POWER_ON || state_ff == ST_STARTED) && on_prog) begin
                  msg_state       = ST_PROG;
                  stop_cmd_in     = in_data_ff.msg_command & CMD_PAIR_MASK;
                  prog_pending_in = 1'b1;
               end
            end
            // Programming lasts one extra tick; stopped safe settles at once.
            state_in = msg_state;
            if (msg_state == ST_PROG) begin
               if (prog_pending_in) begin
                  prog_pending_in = 1'b0;
               end else begin
                  state_in = ST_POWER_ON;
               end
            end else if (msg_state == ST_STOPPED_SAFE) begin
               state_in = ST_STOPPED;
            end
         end
         MODE_MANUAL: begin
            // A press edge turns power on into started; any other state falls back to power on.
            if (!in_data_ff.button_pressed) begin
               button_latched_in = 1'b0;
            end else if (!button_latched_ff) begin
               button_latched_in = 1'b1;
               state_in = (state_ff == ST_POWER_ON) ? ST_STARTED : ST_POWER_ON;
            end
         end
         default: begin
            // Unused modes hold all state.
         end
      endcase

      case (state_in)
         ST_STARTED:      saved = ST_STARTED;
         ST_STOPPED_SAFE: saved = ST_STOPPED_SAFE;
         default:         saved = ST_POWER_ON;
      endcase

      rsp_data_in.pad           = 1'b0;
      rsp_data_in.run_state     = state_in;
      rsp_data_in.started_now   = (state_in == ST_STARTED) && (state_ff != ST_STARTED);
      rsp_data_in.stop_code     = stop_cmd_in;
      rsp_data_in.persist_state = saved;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_mode_ff       <= RESET_RUN_MODE;
         ss_addr_ff        <= RESET_SS_ADDR;
         prog_addr_ff      <= RESET_PROG_ADDR;
         state_ff          <= ST_POWER_ON;
         stop_cmd_ff       <= '0;
         prog_pending_ff   <= 1'b0;
         button_latched_ff <= 1'b0;
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_RUN_MODE:  run_mode_ff  <= csr_data[MODE_W-1:0];
               CSR_SS_ADDR:   ss_addr_ff   <= csr_data[ADDR_W-1:0];
               CSR_PROG_ADDR: prog_addr_ff <= csr_data[ADDR_W-1:0];
               default: begin
                  // Writes beyond the register list are dropped.
               end
            endcase
         end
         if (req_accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            state_ff          <= state_in;
            stop_cmd_ff       <= stop_cmd_in;
            prog_pending_ff   <= prog_pending_in;
            button_latched_ff <= button_latched_in;
            rsp_valid_ff      <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      // Payload registers.
      if (req_accept) begin
         in_msg_valid_ff <= req_tuser;
         in_data_ff      <= req_tdata;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> verif/start_module_state_machine_unit_tb.sv
`timescale 1ns / 1ps

// Testbench for the sumo start-module controller.
//
// Every request transaction is one poll tick and yields exactly one response
// transaction. A behavioral copy of the controller (state, programmed command
// pair, button latch and configuration) runs next to the block. Each accepted
// tick is fed to it, and the predicted status is queued. A checker process
// pulls response transactions from the block and compares them field by
// field against the oldest queued status.
//
// The run starts with short directed tests for remote commands, manual button
// edges, equal start/stop and programming addresses, and the modes that hold
// the state. A long random test follows. Configuration is only written while
// the block is idle, after every queued status has been matched.
module start_module_state_machine_unit_tb;
   import smsm_pkg::*;

   // Controller states, encoded as on the run_state and persist_state fields.
   typedef enum logic [STATE_W-1:0] {
      ST_PROGRAMMING  = 3'd0,
      ST_POWER_ON     = 3'd1,
      ST_STARTED      = 3'd2,
      ST_STOPPED_SAFE = 3'd3,
      ST_STOPPED      = 3'd4
   } run_state_type;

   // Register index that maps to nothing, and the run mode that is not defined.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED   = 2'd3;
   localparam logic [MODE_W-1:0]      MODE_UNDEFINED = 2'd3;

   localparam int unsigned MAX_GAP        = 6;
   localparam int unsigned RANDOM_TICKS   = 2000;
   localparam int unsigned WATCHDOG_LIMIT = 400;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic                   req_tuser;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // Configuration as the controller should currently see it.
   logic [MODE_W-1:0] cfg_mode      = RESET_RUN_MODE;
   logic [ADDR_W-1:0] cfg_ss_addr   = RESET_SS_ADDR;
   logic [ADDR_W-1:0] cfg_prog_addr = RESET_PROG_ADDR;

   // Controller state as it should be after the last accepted tick.
   run_state_type    ctl_state      = ST_POWER_ON;
   logic [CMD_W-1:0] stop_code      = '0;
   logic             prog_pending   = 1'b0;
   logic             button_latched = 1'b0;

   // Status of each accepted tick that has not come back yet, oldest first.
   rsp_data_type expected_status_q[$];

   int unsigned error_count  = 0;
   int unsigned random_ticks = 0;
   int unsigned idle_cycles  = 0;

   // When cleared, the matching side runs without any idle cycle.
   bit sender_idles    = 1'b1;
   bit receiver_stalls = 1'b1;

   start_module_state_machine_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // Advances the controller copy by one poll tick and returns the status
   // that the block has to report for it.
   function automatic rsp_data_type predict_tick(input logic msg_valid,
                                                 input logic [ADDR_W-1:0] address,
                                                 input logic [CMD_W-1:0] command,
                                                 input logic pressed);
      run_state_type prior;
      rsp_data_type  status;
      logic          on_ss;
      logic          on_prog;
      prior   = ctl_state;
      on_ss   = (address == cfg_ss_addr);
      on_prog = (address == cfg_prog_addr);
      if (cfg_mode == MODE_REMOTE) begin
         // Messages only act in power on and started. The checks run in
         // order, so a programming message overrides a start or a stop.
         if (msg_valid && (prior == ST_POWER_ON || prior == ST_STARTED)) begin
            if (prior == ST_POWER_ON && on_ss && command == stop_code + 8'd1) begin
               ctl_state = ST_STARTED;
            end
            if (on_ss && command == stop_code) begin
               ctl_state = ST_STOPPED_SAFE;
            end
            if (on_prog) begin
               ctl_state    = ST_PROGRAMMING;
               stop_code    = command & CMD_PAIR_MASK;
               prog_pending = 1'b1;
            end
         end
         // Programming lasts one extra tick; stopped safe settles at once.
         if (ctl_state == ST_PROGRAMMING) begin
            if (prog_pending) begin
               prog_pending = 1'b0;
            end else begin
               ctl_state = ST_POWER_ON;
            end
         end else if (ctl_state == ST_STOPPED_SAFE) begin
            ctl_state = ST_STOPPED;
         end
      end else if (cfg_mode == MODE_MANUAL) begin
         // A press edge toggles power on to started; any other state
         // falls back to power on.
         if (!pressed) begin
            button_latched = 1'b0;
         end
         if (pressed && !button_latched) begin
            button_latched = 1'b1;
            ctl_state = (ctl_state == ST_POWER_ON) ? ST_STARTED : ST_POWER_ON;
         end
      end
      status             = '0;
      status.run_state   = ctl_state;
      status.started_now = (ctl_state == ST_STARTED && prior != ST_STARTED);
      status.stop_code   = stop_code;
      case (ctl_state)
         ST_STARTED, ST_STOPPED_SAFE: status.persist_state = ctl_state;
         default: status.persist_state = ST_POWER_ON;
      endcase
      return status;
   endfunction

   // Address pick that favors both ends of the range.
   function automatic logic [ADDR_W-1:0] pick_address();
      int unsigned pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return ADDR_W'($urandom);
   endfunction

   // Sends one poll tick as a request transaction. On return the clock edge
   // that accepted it has just passed and req_tvalid is still high, so a
   // back-to-back tick can follow without a bubble.
   task automatic send_tick(input logic msg_valid, input logic [ADDR_W-1:0] address,
                            input logic [CMD_W-1:0] command, input logic pressed);
      req_data_type payload;
      int unsigned  gap;
      payload                = '0;
      payload.msg_address    = address;
      payload.msg_command    = command;
      payload.button_pressed = pressed;
      gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= msg_valid;
      req_tdata  <= payload;
      do @(posedge clock); while (!req_tready);
      expected_status_q.push_back(predict_tick(msg_valid, address, command, pressed));
   endtask

   // Stops sending and waits until every outstanding tick has been answered.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_status_q.size() != 0);
   endtask

   // One configuration write transaction. csr_valid stays high on return so
   // that writes can run back to back; configure lowers it.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_RUN_MODE:  cfg_mode      = value[MODE_W-1:0];
         CSR_SS_ADDR:   cfg_ss_addr   = value;
         CSR_PROG_ADDR: cfg_prog_addr = value;
         default: ;
      endcase
   endtask

   // Waits for the block to go idle and writes all three registers. The mode
   // write carries random upper bits, which the block has to drop. A write to
   // the unmapped index, if asked for, must change nothing.
   task automatic configure(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] ss_addr,
                            input logic [ADDR_W-1:0] prog_addr, input bit poke_unmapped);
      logic [CSR_DATA_W-1:0] word;
      drain_responses();
      word             = CSR_DATA_W'($urandom);
      word[MODE_W-1:0] = mode;
      write_csr(CSR_RUN_MODE, word);
      write_csr(CSR_SS_ADDR, ss_addr);
      write_csr(CSR_PROG_ADDR, prog_addr);
      if (poke_unmapped) begin
         word = CSR_DATA_W'($urandom);
         write_csr(CSR_UNMAPPED, word);
      end
      csr_valid <= 1'b0;
   endtask

   // Remote mode at the reset configuration: start, programming from
   // started, the extra programming tick, a start with the new code, a wrong
   // address, a stop, and messages that must be ignored.
   task automatic test_remote_commands();
      send_tick(1'b0, 5'd7, 8'h01, 1'b0);
      send_tick(1'b1, 5'd7, 8'h01, 1'b1);
      send_tick(1'b1, 5'd11, 8'hFF, 1'b0);
      send_tick(1'b1, 5'd7, 8'hFF, 1'b0);
      send_tick(1'b1, 5'd7, 8'hFF, 1'b0);
      send_tick(1'b1, 5'd31, 8'hFE, 1'b0);
      send_tick(1'b1, 5'd7, 8'hFE, 1'b0);
      send_tick(1'b1, 5'd11, 8'h00, 1'b1);
   endtask

   // Manual mode: a press edge leaves stopped, a held button does nothing,
   // messages are ignored, and started and programming both fall back to
   // power on. The latch is carried across the mode change.
   task automatic test_manual_button();
      configure(MODE_MANUAL, cfg_ss_addr, cfg_prog_addr, 1'b0);
      send_tick(1'b1, 5'd7, 8'hFF, 1'b1);
      send_tick(1'b0, 5'd0, 8'h00, 1'b1);
      send_tick(1'b1, 5'd7, 8'hFE, 1'b0);
      send_tick(1'b0, 5'd0, 8'h00, 1'b1);
      send_tick(1'b0, 5'd0, 8'h00, 1'b0);
      send_tick(1'b1, 5'd7, 8'hFE, 1'b1);
      // Leave the controller in programming, then press again in manual mode.
      configure(MODE_REMOTE, 5'd7, 5'd11, 1'b0);
      send_tick(1'b1, 5'd11, 8'h01, 1'b0);
      configure(MODE_MANUAL, cfg_ss_addr, cfg_prog_addr, 1'b0);
      send_tick(1'b0, 5'd0, 8'h00, 1'b1);
      send_tick(1'b0, 5'd0, 8'h00, 1'b0);
      send_tick(1'b0, 5'd0, 8'h00, 1'b1);
   endtask

   // With both addresses equal, programming wins over start and stop.
   task automatic test_equal_addresses();
      configure(MODE_REMOTE, 5'd31, 5'd31, 1'b0);
      send_tick(1'b1, 5'd31, 8'h01, 1'b0);
      send_tick(1'b0, 5'd31, 8'h01, 1'b0);
      send_tick(1'b1, 5'd31, 8'h00, 1'b0);
   endtask

   // The unused and the undefined mode hold every state bit. The unmapped
   // register write happens while the mode is undefined; a press afterwards
   // would show it if that write had reached the mode register.
   task automatic test_held_modes();
      configure(MODE_UNUSED, cfg_ss_addr, cfg_prog_addr, 1'b0);
      send_tick(1'b1, 5'd31, 8'h01, 1'b1);
      configure(MODE_UNDEFINED, cfg_ss_addr, cfg_prog_addr, 1'b1);
      send_tick(1'b1, 5'd31, 8'h00, 1'b0);
      send_tick(1'b1, 5'd31, 8'h01, 1'b1);
   endtask

   // Random phases, each with its own configuration and idling profile.
   // Remote phases mostly send well-formed start, stop and programming
   // messages. A stuck stopped state is usually left through manual mode.
   task automatic test_random_ticks();
      int unsigned       pick;
      int unsigned       phase_len;
      logic [MODE_W-1:0] mode;
      logic [ADDR_W-1:0] ss_addr;
      logic [ADDR_W-1:0] prog_addr;
      logic              msg_valid;
      logic              pressed;
      logic [ADDR_W-1:0] address;
      logic [CMD_W-1:0]  command;
      while (random_ticks < RANDOM_TICKS) begin
         pick = $urandom_range(0, 9);
         if (pick < 5 && ctl_state != ST_STOPPED) begin
            mode = MODE_REMOTE;
         end else if (pick < 8) begin
            mode = MODE_MANUAL;
         end else if (pick == 8) begin
            mode = MODE_UNUSED;
         end else begin
            mode = MODE_UNDEFINED;
         end
         ss_addr   = pick_address();
         prog_addr = ($urandom_range(0, 5) == 0) ? ss_addr : pick_address();
         configure(mode, ss_addr, prog_addr, $urandom_range(0, 3) == 0);
         sender_idles    = ($urandom_range(0, 3) != 0);
         receiver_stalls = ($urandom_range(0, 3) != 0);
         phase_len       = $urandom_range(10, 60);
         repeat (phase_len) begin
            msg_valid = 1'($urandom_range(0, 1));
            address   = ADDR_W'($urandom);
            command   = CMD_W'($urandom);
            pressed   = 1'($urandom_range(0, 1));
            if (mode == MODE_REMOTE) begin
               msg_valid = ($urandom_range(0, 9) < 8);
               pick      = $urandom_range(0, 9);
               if (pick < 4) begin
                  address = cfg_ss_addr;
               end else if (pick < 6) begin
                  address = cfg_prog_addr;
               end
               pick = $urandom_range(0, 9);
               if (pick < 5) begin
                  command = stop_code + 8'd1;
               end else if (pick < 8) begin
                  command = stop_code;
               end
            end
            send_tick(msg_valid, address, command, pressed);
            random_ticks++;
         end
      end
   endtask

   // Pulls response transactions with random stalls and checks each one
   // against the oldest outstanding status.
   initial begin : response_checker
      rsp_data_type seen;
      rsp_data_type want;
      int unsigned  stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = receiver_stalls ? $urandom_range(0, MAX_GAP) : 0;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         seen = rsp_tdata;
         if (expected_status_q.size() == 0) begin
            $error("response transaction with no tick outstanding: tdata %h", seen);
            error_count++;
         end else begin
            want = expected_status_q.pop_front();
            if (seen.run_state !== want.run_state) begin
               $error("run_state: expected %0d, actual %0d", want.run_state, seen.run_state);
               error_count++;
            end
            if (seen.started_now !== want.started_now) begin
               $error("started_now: expected %0d, actual %0d",
                      want.started_now, seen.started_now);
               error_count++;
            end
            if (seen.stop_code !== want.stop_code) begin
               $error("stop_code: expected %0h, actual %0h", want.stop_code, seen.stop_code);
               error_count++;
            end
            if (seen.persist_state !== want.persist_state) begin
               $error("persist_state: expected %0d, actual %0d",
                      want.persist_state, seen.persist_state);
               error_count++;
            end
         end
      end
   end

   // Ends the run if no transaction of any kind completes for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : test_sequence
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_RUN_MODE;
      csr_data   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_remote_commands();
      test_manual_button();
      test_equal_addresses();
      test_held_modes();
      test_random_ticks();

      // Let the last responses come back, then keep the clock running so that
      // any response that the block should not send can show.
      drain_responses();
      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_status_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
